FILE: design/button_multi_press_classifier_assert.svh
// ----------------------------------------------------------------------------
// Button multi-press classifier assertion macros
// Shared assertion forms for the checker of the button press classifier.
// ----------------------------------------------------------------------------
`ifndef BUTTON_MULTI_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_MULTI_PRESS_CLASSIFIER_ASSERT_SVH

// Property checked on every rising clock edge outside of reset.
`define BMPC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define BMPC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: design/bmpc_pkg.sv
// ----------------------------------------------------------------------------
// Button multi-press classifier package
// Shared widths, register map, event codes and helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bmpc_pkg;

   // Width of the long-press and repeat countdown timers.
   localparam int TIMER_BITS = 16;
   localparam int LOAD_BITS = 16;
   localparam int WIDE_BITS = 33;

   typedef logic [TIMER_BITS-1:0] timer_type;
   typedef logic [7:0] count_type;

   localparam logic [WIDE_BITS-1:0] TIMER_MAX_WIDE =
      (WIDE_BITS'(1) << TIMER_BITS) - WIDE_BITS'(1);
   localparam count_type COUNT_MAX = 8'hFF;

   // Configuration register map (index = byte address / 4).
   localparam int CSR_ADDR_BITS = 4;
   typedef enum logic [1:0] {
      REG_ACTIVE_HIGH    = 2'd0,
      REG_LONG_TICKS     = 2'd1,
      REG_REPEAT_TICKS   = 2'd2,
      REG_MAX_PRESSES    = 2'd3
   } reg_index_type;

   // Input item kinds.
   typedef enum logic {
      KIND_LEVEL = 1'b0,
      KIND_TICK  = 1'b1
   } kind_type;

   // Reported button events.
   typedef enum logic [1:0] {
      CODE_SINGLE = 2'd0,
      CODE_DOUBLE = 2'd1,
      CODE_TRIPLE = 2'd2,
      CODE_LONG   = 2'd3
   } event_code_type;

   // Loads a timer from a register value, saturating at the timer range.
   function automatic timer_type timer_load(input logic [LOAD_BITS-1:0] value);
      logic [WIDE_BITS-1:0] wide;
      wide = {{(WIDE_BITS-LOAD_BITS){1'b0}}, value};
      if (wide > TIMER_MAX_WIDE) begin
         wide = TIMER_MAX_WIDE;
      end
      return wide[TIMER_BITS-1:0];
   endfunction

   // Maps a press count to its event; anything but two or three is single.
   function automatic event_code_type code_of_count(input count_type count);
      event_code_type code;
      if (count == 8'd2) begin
         code = CODE_DOUBLE;
      end else if (count == 8'd3) begin
         code = CODE_TRIPLE;
      end else begin
         code = CODE_SINGLE;
      end
      return code;
   endfunction

endpackage

`default_nettype wire

FILE: design/button_multi_press_classifier.sv
// ----------------------------------------------------------------------------
// Button multi-press classifier
// Turns pin level changes and time ticks into single, double, triple and
// long press events for one button.
// ----------------------------------------------------------------------------
// Usage:
// - The req channel carries one item per transaction: a pin level change
//   (req_kind = 0, req_level_high = new level) or one time tick (req_kind = 1).
// - The rsp channel carries one transaction per reported button event; most
//   items report nothing and produce no transaction.
// - The state is updated at the clock edge that accepts an item, and any event
//   appears on rsp in the next cycle, held in the output register.
// - Throughput is one item per cycle; the single output register sets it.
//   While a result waits and rsp_ready is low, req_ready is low; a result
//   taken in the same cycle frees the register for the next item.
// - The user writes configuration over the csr APB port only while the block is
//   idle (unenforced); reads give the stored value; csr_pready is always high.
// - Synchronous reset clears the press count and disarms both timers, drops
//   any pending result and returns the registers to their reset values
//   (low active level, both timeouts disabled, max presses of one).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module button_multi_press_classifier (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input item channel.
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_kind,
   input  wire logic        req_level_high,
   // Result channel.
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_event_valid,
   output logic [1:0]       rsp_event_code,
   // Configuration port.
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [bmpc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // Configuration registers.
   logic        active_high_ff;
   logic [15:0] long_ticks_ff;
   logic [15:0] repeat_ticks_ff;
   logic [7:0]  max_presses_ff;

   // Classifier state.
   bmpc_pkg::count_type press_count_ff, press_count_in;
   bmpc_pkg::timer_type long_rem_ff, long_rem_in;
   logic                long_armed_ff, long_armed_in;
   bmpc_pkg::timer_type repeat_rem_ff, repeat_rem_in;
   logic                repeat_armed_ff, repeat_armed_in;

   // Output register.
   logic                     rsp_valid_ff;
   bmpc_pkg::event_code_type rsp_code_ff;

   // Per-item results.
   logic                     emit;
   bmpc_pkg::event_code_type emit_code;
   logic                     req_accept;
   logic                     csr_write;
   bmpc_pkg::reg_index_type  csr_index;

   // Timer countdown terms for a tick.
   bmpc_pkg::timer_type long_dec;
   bmpc_pkg::timer_type repeat_dec;
   bmpc_pkg::count_type count_inc;

   assign csr_pready = 1'b1;
   assign csr_index  = bmpc_pkg::reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register write port.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_high_ff  <= 1'b0;
         long_ticks_ff   <= 16'd0;
         repeat_ticks_ff <= 16'd0;
         max_presses_ff  <= 8'd1;
      end else if (csr_write) begin
         unique case (csr_index)
            bmpc_pkg::REG_ACTIVE_HIGH:  active_high_ff  <= csr_pwdata[0];
            bmpc_pkg::REG_LONG_TICKS:   long_ticks_ff   <= csr_pwdata[15:0];
            bmpc_pkg::REG_REPEAT_TICKS: repeat_ticks_ff <= csr_pwdata[15:0];
            bmpc_pkg::REG_MAX_PRESSES:  max_presses_ff  <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Register read mux.
   always_comb begin
      unique case (csr_index)
         bmpc_pkg::REG_ACTIVE_HIGH:  csr_prdata = {31'd0, active_high_ff};
         bmpc_pkg::REG_LONG_TICKS:   csr_prdata = {16'd0, long_ticks_ff};
         bmpc_pkg::REG_REPEAT_TICKS: csr_prdata = {16'd0, repeat_ticks_ff};
         bmpc_pkg::REG_MAX_PRESSES:  csr_prdata = {24'd0, max_presses_ff};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   // An item is taken whenever the output register is empty or draining.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   // Countdown values: an armed timer at zero stays at zero and expires.
   assign long_dec   = (long_rem_ff != '0) ? long_rem_ff - bmpc_pkg::timer_type'(1) : '0;
   assign repeat_dec = (repeat_rem_ff != '0) ? repeat_rem_ff - bmpc_pkg::timer_type'(1) : '0;
   assign count_inc  = (press_count_ff == bmpc_pkg::COUNT_MAX) ?
                       press_count_ff : press_count_ff + 8'd1;

   // Next state and result for the item on the input.
   always_comb begin
      press_count_in  = press_count_ff;
      long_rem_in     = long_rem_ff;
      long_armed_in   = long_armed_ff;
      repeat_rem_in   = repeat_rem_ff;
      repeat_armed_in = repeat_armed_ff;
      emit            = 1'b0;
      emit_code       = bmpc_pkg::CODE_SINGLE;

      if (req_kind == bmpc_pkg::KIND_TICK) begin
         // Both armed timers count down; long press wins a shared expiry.
         if (long_armed_ff) begin
            long_rem_in = long_dec;
            if (long_dec == '0) begin
               long_armed_in = 1'b0;
            end
         end
         if (repeat_armed_ff) begin
            repeat_rem_in = repeat_dec;
            if (repeat_dec == '0) begin
               repeat_armed_in = 1'b0;
            end
         end
         if (long_armed_ff && long_dec == '0) begin
            emit           = 1'b1;
            emit_code      = bmpc_pkg::CODE_LONG;
            press_count_in = '0;
         end else if (repeat_armed_ff && repeat_dec == '0) begin
            emit           = 1'b1;
            emit_code      = bmpc_pkg::code_of_count(press_count_ff);
            press_count_in = '0;
         end
      end else if (req_level_high == active_high_ff) begin
         // Press: count up, and the first press arms the long timer if its load is nonzero.
         press_count_in = count_inc;
         if (press_count_ff == '0 && long_ticks_ff != 16'd0) begin
            long_rem_in   = bmpc_pkg::timer_load(long_ticks_ff);
            long_armed_in = 1'b1;
         end
      end else if (press_count_ff != '0) begin
         // Release: report at once or wait for a further press.
         long_armed_in = 1'b0;
         if (press_count_ff >= max_presses_ff || repeat_ticks_ff == 16'd0) begin
            repeat_armed_in = 1'b0;
            emit            = 1'b1;
            emit_code       = bmpc_pkg::code_of_count(press_count_ff);
            press_count_in  = '0;
         end else begin
            repeat_rem_in   = bmpc_pkg::timer_load(repeat_ticks_ff);
            repeat_armed_in = 1'b1;
         end
      end
   end

   // State registers, updated on each accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         press_count_ff  <= '0;
         long_rem_ff     <= '0;
         long_armed_ff   <= 1'b0;
         repeat_rem_ff   <= '0;
         repeat_armed_ff <= 1'b0;
      end else if (req_accept) begin
         press_count_ff  <= press_count_in;
         long_rem_ff     <= long_rem_in;
         long_armed_ff   <= long_armed_in;
         repeat_rem_ff   <= repeat_rem_in;
         repeat_armed_ff <= repeat_armed_in;
      end
   end

   // Output register: loaded by a reporting item, cleared when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && emit) begin
         rsp_code_ff <= emit_code;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_valid = rsp_valid_ff;
   assign rsp_event_code  = rsp_code_ff;

endmodule

`default_nettype wire

FILE: design/bmpc_checker.sv
// ----------------------------------------------------------------------------
// Button multi-press classifier checker
// Port-level checks on the classifier, attached to that module by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "button_multi_press_classifier_assert.svh"

module bmpc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_event_valid,
   input wire logic [1:0] rsp_event_code,
   input wire logic       csr_pready
);

   // A stalled result keeps its event code until it is taken.
   `BMPC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_code), "result changed while stalled")

   // Every result transaction reports an event.
   `BMPC_ASSERT(a_event_flag, rsp_valid |-> rsp_event_valid, "result without event flag")

   // A full, stalled output register blocks new items.
   `BMPC_ASSERT(a_no_overrun, rsp_valid && !rsp_ready |-> !req_ready, "item taken over a held result")

   // Reset drops any pending result.
   `BMPC_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result present after reset")

   // The configuration port never inserts wait states.
   `BMPC_ASSERT_ALWAYS(a_pready, csr_pready, "configuration port not ready")

endmodule

bind button_multi_press_classifier bmpc_checker u_bmpc_checker (.*);

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button multi-press classifier testbench
// Drives level changes and ticks into the classifier, predicts every button
// event from a local copy of its state and configuration, and compares each
// result transaction field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------

module tb_top;

   localparam int RANDOM_ITEMS    = 1100;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int IDLE_CYCLES     = 4;
   localparam int DRAIN_CYCLES    = 5000;
   localparam int RUN_LIMIT_NS    = 4_000_000;
   localparam int PRINT_LIMIT     = 30;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = 1'b0;
   logic        req_level_high = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_event_valid;
   logic [1:0]  rsp_event_code;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [bmpc_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Shadow of the configuration registers (reset values).
   logic        cfg_level_on = 1'b0;
   logic [15:0] cfg_hold_ticks = 16'd0;
   logic [15:0] cfg_gap_ticks = 16'd0;
   logic [7:0]  cfg_press_limit = 8'd1;

   // Predicted classifier state.
   logic [7:0]  press_tally = 8'd0;
   logic [15:0] hold_timer = 16'd0;
   logic        hold_timer_on = 1'b0;
   logic [15:0] gap_timer = 16'd0;
   logic        gap_timer_on = 1'b0;

   bmpc_pkg::event_code_type pending_events[$];
   int error_count = 0;
   int items_sent = 0;
   int burst_left = 0;
   bit hold_off_req = 1'b0;

   button_multi_press_classifier DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_level_high  (req_level_high),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_valid (rsp_event_valid),
      .rsp_event_code  (rsp_event_code),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // Free-running clock with a 4 ns period.
   initial begin
      forever #2 clock = ~clock;
   end

   // Hard limit on the run time in case the block hangs.
   initial begin
      #(RUN_LIMIT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

   // Prints one line per mismatch, up to a limit, and counts every one.
   task automatic report_mismatch(input string what);
      if (error_count < PRINT_LIMIT) begin
         $display("MISMATCH at %0t ns: %s", $time, what);
      end
      error_count++;
   endtask

   // Only a count of two or three has a code of its own.
   function automatic bmpc_pkg::event_code_type tally_to_code(input logic [7:0] tally);
      if (tally == 8'd2) begin
         return bmpc_pkg::CODE_DOUBLE;
      end else if (tally == 8'd3) begin
         return bmpc_pkg::CODE_TRIPLE;
      end
      return bmpc_pkg::CODE_SINGLE;
   endfunction

   // Advances the predicted state by one item; returns 1 when an event is due.
   function automatic bit classify_step(input bmpc_pkg::kind_type kind, input logic level,
                                        output bmpc_pkg::event_code_type code);
      bit hold_fire;
      bit gap_fire;
      code = bmpc_pkg::CODE_SINGLE;
      hold_fire = 1'b0;
      gap_fire = 1'b0;
      if (kind == bmpc_pkg::KIND_TICK) begin
         if (hold_timer_on) begin
            if (hold_timer != 16'd0) hold_timer--;
            if (hold_timer == 16'd0) begin
               hold_timer_on = 1'b0;
               hold_fire = 1'b1;
            end
         end
         if (gap_timer_on) begin
            if (gap_timer != 16'd0) gap_timer--;
            if (gap_timer == 16'd0) begin
               gap_timer_on = 1'b0;
               gap_fire = 1'b1;
            end
         end
         // Long press wins; an expiring repeat timer is then dropped silently.
         if (hold_fire) begin
            press_tally = 8'd0;
            code = bmpc_pkg::CODE_LONG;
            return 1'b1;
         end
         if (gap_fire) begin
            code = tally_to_code(press_tally);
            press_tally = 8'd0;
            return 1'b1;
         end
         return 1'b0;
      end

      // Press: saturating count, long timer armed only by the first press.
      if (level == cfg_level_on) begin
         if (press_tally != 8'hFF) press_tally++;
         if (press_tally == 8'd1 && cfg_hold_ticks != 16'd0) begin
            hold_timer = cfg_hold_ticks;
            hold_timer_on = 1'b1;
         end
         return 1'b0;
      end

      // Release with nothing pressed is ignored.
      if (press_tally == 8'd0) return 1'b0;
      hold_timer_on = 1'b0;
      if (press_tally >= cfg_press_limit || cfg_gap_ticks == 16'd0) begin
         gap_timer_on = 1'b0;
         code = tally_to_code(press_tally);
         press_tally = 8'd0;
         return 1'b1;
      end
      gap_timer = cfg_gap_ticks;
      gap_timer_on = 1'b1;
      return 1'b0;
   endfunction

   // Predicts on each accepted item and checks each accepted result transaction.
   always @(posedge clock) begin : track_results
      bmpc_pkg::event_code_type predicted;
      bmpc_pkg::event_code_type oldest;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (classify_step(bmpc_pkg::kind_type'(req_kind), req_level_high,
                              predicted)) begin
               pending_events.push_back(predicted);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_events.size() == 0) begin
               report_mismatch($sformatf("unexpected result, code %0d", rsp_event_code));
            end else begin
               oldest = pending_events.pop_front();
               if (rsp_event_valid !== 1'b1) begin
                  report_mismatch($sformatf("event_valid %b, expected 1", rsp_event_valid));
               end
               if (rsp_event_code !== oldest) begin
                  report_mismatch($sformatf("event_code %0d, expected %0d",
                                            rsp_event_code, oldest));
               end
            end
         end
      end
   end

   // Result receiver: stall patterns that change at random, plus a long hold-off
   // on request.
   initial begin : rsp_stall_pattern
      int mode_left;
      int stall_pct;
      int held;
      mode_left = 0;
      stall_pct = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            for (held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode_left = $urandom_range(20, 200);
               case ($urandom_range(0, 4))
                  0, 1: stall_pct = 0;
                  2: stall_pct = 25;
                  3: stall_pct = 60;
                  default: stall_pct = 90;
               endcase
            end
            mode_left--;
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // Sends one item; the sender works in bursts with random gaps in between.
   task automatic send_item(input bmpc_pkg::kind_type kind, input logic level);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_kind <= kind;
      req_level_high <= level;
      do @(posedge clock); while (req_ready !== 1'b1);
      items_sent++;
   endtask

   task automatic press_button();
      send_item(bmpc_pkg::KIND_LEVEL, cfg_level_on);
   endtask

   task automatic release_button();
      send_item(bmpc_pkg::KIND_LEVEL, ~cfg_level_on);
   endtask

   task automatic tick_once();
      send_item(bmpc_pkg::KIND_TICK, 1'($urandom_range(0, 1)));
   endtask

   // Waits until every predicted event has arrived and the block is quiet.
   // The first edge lets the prediction for the last accepted item land.
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_events.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle; the register updates at its end.
   task automatic csr_write(input bmpc_pkg::reg_index_type idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= bmpc_pkg::CSR_ADDR_BITS'({idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         bmpc_pkg::REG_ACTIVE_HIGH: cfg_level_on = value[0];
         bmpc_pkg::REG_LONG_TICKS: cfg_hold_ticks = value[15:0];
         bmpc_pkg::REG_REPEAT_TICKS: cfg_gap_ticks = value[15:0];
         bmpc_pkg::REG_MAX_PRESSES: cfg_press_limit = value[7:0];
         default: ;
      endcase
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // APB read, sampled at the end of the access cycle and compared to the shadow.
   task automatic verify_register(input bmpc_pkg::reg_index_type idx);
      logic [31:0] expected;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= bmpc_pkg::CSR_ADDR_BITS'({idx, 2'b00});
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         bmpc_pkg::REG_ACTIVE_HIGH: expected = {31'd0, cfg_level_on};
         bmpc_pkg::REG_LONG_TICKS: expected = {16'd0, cfg_hold_ticks};
         bmpc_pkg::REG_REPEAT_TICKS: expected = {16'd0, cfg_gap_ticks};
         default: expected = {24'd0, cfg_press_limit};
      endcase
      if (csr_prdata !== expected) begin
         report_mismatch($sformatf("register %s reads %h, expected %h",
                                   idx.name(), csr_prdata, expected));
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Writes the whole configuration once the block is idle.
   task automatic apply_config(input logic level_on, input logic [15:0] hold,
                               input logic [15:0] gap, input logic [7:0] limit);
      wait_idle();
      csr_write(bmpc_pkg::REG_ACTIVE_HIGH, {31'd0, level_on});
      csr_write(bmpc_pkg::REG_LONG_TICKS, {16'd0, hold});
      csr_write(bmpc_pkg::REG_REPEAT_TICKS, {16'd0, gap});
      csr_write(bmpc_pkg::REG_MAX_PRESSES, {24'd0, limit});
   endtask

   // Reset values, write and read-back of every register, bits above the
   // register width, then back to the reset configuration.
   task automatic test_register_access();
      verify_register(bmpc_pkg::REG_ACTIVE_HIGH);
      verify_register(bmpc_pkg::REG_LONG_TICKS);
      verify_register(bmpc_pkg::REG_REPEAT_TICKS);
      verify_register(bmpc_pkg::REG_MAX_PRESSES);
      csr_write(bmpc_pkg::REG_ACTIVE_HIGH, 32'hFFFF_FFFF);
      verify_register(bmpc_pkg::REG_ACTIVE_HIGH);
      csr_write(bmpc_pkg::REG_LONG_TICKS, 32'h1234_FFFF);
      verify_register(bmpc_pkg::REG_LONG_TICKS);
      csr_write(bmpc_pkg::REG_REPEAT_TICKS, 32'h0000_A5C3);
      verify_register(bmpc_pkg::REG_REPEAT_TICKS);
      csr_write(bmpc_pkg::REG_MAX_PRESSES, 32'h0000_00FF);
      verify_register(bmpc_pkg::REG_MAX_PRESSES);
      csr_write(bmpc_pkg::REG_MAX_PRESSES, 32'hABCD_EF00);
      verify_register(bmpc_pkg::REG_MAX_PRESSES);
      apply_config(1'b0, 16'd0, 16'd0, 8'd1);
   endtask

   // Short hand-written sequences over the main cases.
   task automatic test_directed();
      // Reset configuration: a stray release, a single press and an idle tick.
      release_button();
      press_button();
      release_button();
      tick_once();

      apply_config(1'b1, 16'd3, 16'd2, 8'd3);
      // Long press, then its release finds a zero count.
      press_button();
      repeat (3) tick_once();
      release_button();
      // Repeat timer runs out while the second press is still held.
      press_button();
      release_button();
      press_button();
      repeat (2) tick_once();
      release_button();
      // Third press reaches the limit and reports at once.
      repeat (3) begin
         press_button();
         release_button();
      end

      // Largest timers, limit of zero: the release reports at once.
      apply_config(1'b0, 16'hFFFF, 16'hFFFF, 8'd0);
      press_button();
      release_button();
   endtask

   // Long receiver hold-off with a steady stream of results behind it.
   task automatic test_output_backpressure();
      apply_config(1'b0, 16'd0, 16'd0, 8'd1);
      hold_off_req = 1'b1;
      repeat (20) begin
         press_button();
         release_button();
      end
   endtask

   // Button held through enough press events to saturate the count.
   task automatic test_held_button_saturation();
      int presses;
      apply_config(1'($urandom_range(0, 1)), 16'd0, 16'd0, 8'hFF);
      presses = $urandom_range(255, 262);
      repeat (presses) press_button();
      release_button();
      release_button();
   endtask

   // Random configurations, each followed by random gestures and some noise.
   task automatic test_random_gestures();
      int stop_at;
      int phase_end;
      int presses;
      int hold_span;
      int gap_span;
      int i;
      logic [15:0] hold;
      logic [15:0] gap;
      logic [7:0] limit;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         case ($urandom_range(0, 9))
            0, 1: hold = 16'd0;
            2: hold = 16'd1;
            9: hold = 16'hFFFF;
            default: hold = 16'($urandom_range(2, 12));
         endcase
         case ($urandom_range(0, 9))
            0, 1: gap = 16'd0;
            2: gap = 16'd1;
            9: gap = 16'hFFFF;
            default: gap = 16'($urandom_range(2, 10));
         endcase
         case ($urandom_range(0, 7))
            0: limit = 8'hFF;
            1: limit = 8'($urandom_range(0, 255));
            default: limit = 8'($urandom_range(0, 6));
         endcase
         apply_config(1'($urandom_range(0, 1)), hold, gap, limit);
         hold_span = (cfg_hold_ticks > 16'd14) ? 14 : int'(cfg_hold_ticks);
         gap_span = (cfg_gap_ticks > 16'd12) ? 12 : int'(cfg_gap_ticks);
         phase_end = items_sent + $urandom_range(60, 160);
         while (items_sent < phase_end) begin
            if ($urandom_range(0, 99) < 15) begin
               // Noise: any item at all.
               send_item(bmpc_pkg::kind_type'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            end else begin
               // A group of presses with random hold and gap times.
               presses = $urandom_range(1, 6);
               for (i = 0; i < presses; i++) begin
                  press_button();
                  repeat ($urandom_range(0, hold_span + 2)) tick_once();
                  release_button();
                  if (i < presses - 1) begin
                     repeat ($urandom_range(0, gap_span)) tick_once();
                  end
               end
               repeat ($urandom_range(0, gap_span + 3)) tick_once();
            end
         end
      end
   endtask

   // Test sequence.
   initial begin : run_tests
      int waited;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_access();
      test_directed();
      test_output_backpressure();
      test_held_button_saturation();
      test_random_gestures();

      // Let every outstanding result arrive, then settle.
      req_valid <= 1'b0;
      @(posedge clock);
      for (waited = 0; waited < DRAIN_CYCLES && pending_events.size() != 0; waited++) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (pending_events.size() != 0) begin
         report_mismatch($sformatf("%0d expected results never arrived",
                                   pending_events.size()));
      end
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+design
design/bmpc_pkg.sv
design/button_multi_press_classifier.sv
design/bmpc_checker.sv
verif/tb_top.sv
